FILE: hw/rtl/load_store_address_data_unit_defines.svh
// assertion macros for the load/store unit checker
// each macro assumes clk_i and rst_ni are visible where it is used
`ifndef LOAD_STORE_ADDRESS_DATA_UNIT_DEFINES_SVH
`define LOAD_STORE_ADDRESS_DATA_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LSAD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, disabled during reset
`define LSAD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: hw/rtl/lsad_pkg.sv
package lsad_pkg;

  // default depth of the internal queues
  localparam int unsigned QueueDepthDef = 2;

  // instruction word bit positions
  localparam int unsigned BitImmReg = 25;
  localparam int unsigned BitPre    = 24;
  localparam int unsigned BitUp     = 23;
  localparam int unsigned BitByte   = 22;
  localparam int unsigned BitWback  = 21;
  localparam int unsigned BitLoad   = 20;

  // store from r15 stores instruction address plus this
  localparam logic [31:0] PcStoreOffset = 32'd12;
  localparam logic [3:0]  RegPc         = 4'd15;

  typedef enum logic {
    MODE_ISSUE = 1'b0,
    MODE_READ  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    SHIFT_LSL = 2'd0,
    SHIFT_LSR = 2'd1,
    SHIFT_ASR = 2'd2,
    SHIFT_ROR = 2'd3
  } shift_e;

  // classified item handed from front to back
  typedef struct packed {
    mode_e       mode;
    logic        is_load;
    logic        is_byte;
    logic        pre;
    logic        up;
    logic        wb_en;
    logic [3:0]  rn;
    logic [3:0]  rd;
    logic [31:0] base;
    logic [31:0] offset;
    logic [31:0] data;     // store data on issue, bus read data on return
  } dec_t;

  // one finished result
  typedef struct packed {
    logic        bus_valid;
    logic        bus_write;
    logic        bus_byte;
    logic [31:0] bus_address;
    logic [31:0] bus_write_data;
    logic        wb_valid;
    logic [3:0]  wb_reg;
    logic [31:0] wb_value;
    logic        load_valid;
    logic [3:0]  load_reg;
    logic [31:0] load_value;
  } res_t;

endpackage

FILE: hw/rtl/lsad_queue.sv
module lsad_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = lsad_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  // pointer wrap and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: hw/rtl/lsad_front.sv
module lsad_front (
  input  logic                push_i,
  output logic                full_o,
  input  logic                mode_i,
  input  logic [31:0]         instruction_i,
  input  logic [31:0]         base_value_i,
  input  logic [31:0]         offset_reg_value_i,
  input  logic [31:0]         store_value_i,
  input  logic                carry_flag_i,
  input  logic [31:0]         instr_address_i,
  input  logic [31:0]         read_data_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output lsad_pkg::dec_t      dec_o
);

  lsad_pkg::shift_e kind;
  logic [4:0]       amt;
  logic [5:0]       amt_inv;
  logic [31:0]      rmv;
  logic [31:0]      shifted;
  logic [31:0]      st_val;
  logic             is_load, pre, wback, is_byte;
  logic [3:0]       rn, rd;

  // accept a beat whenever the decoded queue has room
  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;

  assign kind    = lsad_pkg::shift_e'(instruction_i[6:5]);
  assign amt     = instruction_i[11:7];
  assign amt_inv = 6'd32 - {1'b0, amt};
  assign rmv     = offset_reg_value_i;

  // immediate-amount barrel shift of rm
  always_comb begin
    case (kind)
      lsad_pkg::SHIFT_LSL: shifted = rmv << amt;
      lsad_pkg::SHIFT_LSR: shifted = (amt == '0) ? '0 : (rmv >> amt);
      lsad_pkg::SHIFT_ASR: begin
        shifted = (amt == '0) ? {32{rmv[31]}} : 32'($signed(rmv) >>> amt);
      end
      lsad_pkg::SHIFT_ROR: begin
        shifted = (amt == '0) ? {carry_flag_i, rmv[31:1]}
                              : ((rmv >> amt) | (rmv << amt_inv));
      end
      default: shifted = rmv;
    endcase
  end

  assign is_load = instruction_i[lsad_pkg::BitLoad];
  assign pre     = instruction_i[lsad_pkg::BitPre];
  assign wback   = instruction_i[lsad_pkg::BitWback];
  assign is_byte = instruction_i[lsad_pkg::BitByte];
  assign rn      = instruction_i[19:16];
  assign rd      = instruction_i[15:12];

  // store data, r15 reads as instruction address plus twelve
  always_comb begin
    st_val = (rd == lsad_pkg::RegPc) ? (instr_address_i + lsad_pkg::PcStoreOffset)
                                     : store_value_i;
    if (is_byte) begin
      st_val = {24'd0, st_val[7:0]};
    end
  end

  // classify the beat
  always_comb begin
    dec_o.mode    = lsad_pkg::mode_e'(mode_i);
    dec_o.is_load = is_load;
    dec_o.is_byte = is_byte;
    dec_o.pre     = pre;
    dec_o.up      = instruction_i[lsad_pkg::BitUp];
    dec_o.wb_en   = (!pre || wback) && !(is_load && (rn == rd));
    dec_o.rn      = rn;
    dec_o.rd      = rd;
    dec_o.base    = base_value_i;
    dec_o.offset  = instruction_i[lsad_pkg::BitImmReg] ? shifted
                                                        : {20'd0, instruction_i[11:0]};
    dec_o.data    = (mode_i == lsad_pkg::MODE_READ) ? read_data_i
                                                    : (is_load ? '0 : st_val);
  end

endmodule

FILE: hw/rtl/lsad_back.sv
module lsad_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lsad_pkg::dec_t  dec_i,
  input  logic            dec_empty_i,
  output logic            dec_pop_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output lsad_pkg::res_t  res_o
);

  logic        load_pending_q, load_pending_d;
  logic [3:0]  pending_dest_q, pending_dest_d;
  logic [1:0]  pending_byte_offset_q, pending_byte_offset_d;
  logic        pending_is_byte_q, pending_is_byte_d;
  logic        step;
  logic [31:0] post, addr, rot_val;

  // carry out one item per cycle while the result queue has room
  assign step       = !dec_empty_i && !res_full_i;
  assign dec_pop_o  = step;
  assign res_push_o = step;

  assign post = dec_i.up ? (dec_i.base + dec_i.offset) : (dec_i.base - dec_i.offset);
  assign addr = dec_i.pre ? post : dec_i.base;

  // rotate a misaligned word by the pending byte offset
  always_comb begin
    case (pending_byte_offset_q)
      2'd1:    rot_val = {dec_i.data[7:0],  dec_i.data[31:8]};
      2'd2:    rot_val = {dec_i.data[15:0], dec_i.data[31:16]};
      2'd3:    rot_val = {dec_i.data[23:0], dec_i.data[31:24]};
      default: rot_val = dec_i.data;
    endcase
  end

  // result and pending-load update
  always_comb begin
    res_o                 = '0;
    load_pending_d        = load_pending_q;
    pending_dest_d        = pending_dest_q;
    pending_byte_offset_d = pending_byte_offset_q;
    pending_is_byte_d     = pending_is_byte_q;
    if (dec_i.mode == lsad_pkg::MODE_READ) begin
      if (load_pending_q) begin
        res_o.load_valid = 1'b1;
        res_o.load_reg   = pending_dest_q;
        res_o.load_value = pending_is_byte_q ? {24'd0, dec_i.data[7:0]} : rot_val;
      end
      load_pending_d = 1'b0;
    end else begin
      res_o.bus_valid      = 1'b1;
      res_o.bus_write      = !dec_i.is_load;
      res_o.bus_byte       = dec_i.is_byte;
      res_o.bus_address    = dec_i.is_byte ? addr : {addr[31:2], 2'b00};
      res_o.bus_write_data = dec_i.data;
      if (dec_i.wb_en) begin
        res_o.wb_valid = 1'b1;
        res_o.wb_reg   = dec_i.rn;
        res_o.wb_value = post;
      end
      load_pending_d        = dec_i.is_load;
      pending_dest_d        = dec_i.is_load ? dec_i.rd : '0;
      pending_byte_offset_d = dec_i.is_load ? addr[1:0] : '0;
      pending_is_byte_d     = dec_i.is_load && dec_i.is_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pending_q        <= 1'b0;
      pending_dest_q        <= '0;
      pending_byte_offset_q <= '0;
      pending_is_byte_q     <= 1'b0;
    end else if (step) begin
      load_pending_q        <= load_pending_d;
      pending_dest_q        <= pending_dest_d;
      pending_byte_offset_q <= pending_byte_offset_d;
      pending_is_byte_q     <= pending_is_byte_d;
    end
  end

endmodule

FILE: hw/rtl/load_store_address_data_unit.sv
// load/store address and data unit for word and byte ldr/str
// input side is a queue: drive the item fields with push_i, a beat is taken
// when push_i is high and full_o is low. mode_i = 0 issues an instruction,
// mode_i = 1 returns bus read data for the pending load.
// result side is a queue: the oldest result sits on the result ports while
// empty_o is low, and pop_i with empty_o low takes that beat.
// every input beat gives exactly one result beat, in order.
// a taken input beat is written into the decode queue, then the execute stage
// carries it into the result queue, whose oldest entry drives the result ports.
// throughput: one beat per cycle while the result queue has room, set by the
// execute stage that owns the pending-load state.
// when pop_i stays low the result queue fills, the execute stage halts, and
// full_o rises once the decode queue is full too (QueueDepth beats each side).
// reset empties both queues and clears the pending load.
module load_store_address_data_unit #(
  parameter int unsigned QueueDepth = lsad_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic        mode_i,
  input  logic [31:0] instruction_i,
  input  logic [31:0] base_value_i,
  input  logic [31:0] offset_reg_value_i,
  input  logic [31:0] store_value_i,
  input  logic        carry_flag_i,
  input  logic [31:0] instr_address_i,
  input  logic [31:0] read_data_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic        bus_valid_o,
  output logic        bus_write_o,
  output logic        bus_byte_o,
  output logic [31:0] bus_address_o,
  output logic [31:0] bus_write_data_o,
  output logic        wb_valid_o,
  output logic [3:0]  wb_reg_o,
  output logic [31:0] wb_value_o,
  output logic        load_valid_o,
  output logic [3:0]  load_reg_o,
  output logic [31:0] load_value_o
);

  localparam int unsigned DecW = $bits(lsad_pkg::dec_t);
  localparam int unsigned ResW = $bits(lsad_pkg::res_t);

  lsad_pkg::dec_t   dec_in, dec_out;
  lsad_pkg::res_t   res_in, res_out;
  logic             dec_push, dec_full, res_push, res_full;
  logic             dec_empty, dec_pop;
  logic [DecW-1:0]  dec_rd;
  logic [ResW-1:0]  res_rd;

  // front: accept and classify
  lsad_front u_front (
    .push_i             (push_i),
    .full_o             (full_o),
    .mode_i             (mode_i),
    .instruction_i      (instruction_i),
    .base_value_i       (base_value_i),
    .offset_reg_value_i (offset_reg_value_i),
    .store_value_i      (store_value_i),
    .carry_flag_i       (carry_flag_i),
    .instr_address_i    (instr_address_i),
    .read_data_i        (read_data_i),
    .q_full_i           (dec_full),
    .q_push_o           (dec_push),
    .dec_o              (dec_in)
  );

  // queue between front and back
  lsad_queue #(
    .Width (DecW),
    .Depth (QueueDepth)
  ) u_dec_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (dec_push),
    .data_i  (DecW'(dec_in)),
    .full_o  (dec_full),
    .pop_i   (dec_pop),
    .data_o  (dec_rd),
    .empty_o (dec_empty)
  );

  assign dec_out = lsad_pkg::dec_t'(dec_rd);

  // back: address, writeback and load completion
  lsad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dec_i       (dec_out),
    .dec_empty_i (dec_empty),
    .dec_pop_o   (dec_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue toward the consumer
  lsad_queue #(
    .Width (ResW),
    .Depth (QueueDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (ResW'(res_in)),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (res_rd),
    .empty_o (empty_o)
  );

  assign res_out          = lsad_pkg::res_t'(res_rd);
  assign bus_valid_o      = res_out.bus_valid;
  assign bus_write_o      = res_out.bus_write;
  assign bus_byte_o       = res_out.bus_byte;
  assign bus_address_o    = res_out.bus_address;
  assign bus_write_data_o = res_out.bus_write_data;
  assign wb_valid_o       = res_out.wb_valid;
  assign wb_reg_o         = res_out.wb_reg;
  assign wb_value_o       = res_out.wb_value;
  assign load_valid_o     = res_out.load_valid;
  assign load_reg_o       = res_out.load_reg;
  assign load_value_o     = res_out.load_value;

endmodule

FILE: hw/rtl/lsad_checker.sv
`include "load_store_address_data_unit_defines.svh"

module lsad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty_o,
  input logic        pop_i,
  input logic        bus_valid_o,
  input logic        bus_write_o,
  input logic        bus_byte_o,
  input logic [31:0] bus_address_o,
  input logic        wb_valid_o,
  input logic        load_valid_o,
  input logic [31:0] load_value_o
);

  logic res_seen;
  logic res_wait;
  logic word_acc;
  logic idle_clear;

  // result-side terms
  assign res_seen   = !empty_o;
  assign res_wait   = !empty_o && !pop_i;
  assign word_acc   = !empty_o && bus_valid_o && !bus_byte_o;
  assign idle_clear = !wb_valid_o && !bus_write_o && (bus_address_o == 32'd0) &&
                      (load_value_o == 32'd0);

  // a waiting result beat holds until taken
  `LSAD_ASSERT_NEXT(a_res_hold, res_wait, res_seen && $stable({bus_address_o, load_value_o}))

  // a load completion carries no bus access and no writeback
  `LSAD_ASSERT_NOW(a_load_alone, res_seen && load_valid_o, !bus_valid_o && !wb_valid_o)

  // word accesses are word aligned
  `LSAD_ASSERT_NOW(a_word_align, word_acc, bus_address_o[1:0] == 2'b00)

  // a result with neither bus access nor load is all zero
  `LSAD_ASSERT_NOW(a_idle_zero, res_seen && !bus_valid_o && !load_valid_o, idle_clear)

endmodule

bind load_store_address_data_unit lsad_checker u_lsad_checker (.*);
